// ===== sv/rrjd_pkg.sv =====
// rrjd_pkg: types and codes for the round-robin job dispatcher
// command and result transaction structs, queue entry layouts, sequencer states
// no dependencies
package rrjd_pkg;

	typedef enum logic {
		OP_SUBMIT = 1'b0,
		OP_TICK   = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		EV_ACCEPTED  = 4'd0,
		EV_REJECTED  = 4'd1,
		EV_ARRIVED   = 4'd2,
		EV_RAN       = 4'd3,
		EV_FINISHED  = 4'd4,
		EV_PREEMPTED = 4'd5,
		EV_STARTED   = 4'd6,
		EV_RESUMED   = 4'd7,
		EV_IDLE      = 4'd8
	} event_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [7:0]  job_tag;
		logic [15:0] arrival_time;
		logic [15:0] cpu_time;
	} cmd_t;

	typedef struct packed {
		event_t      event_res;
		logic [7:0]  event_tag;
		logic [15:0] remaining_time;
		logic [15:0] tick_time;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [7:0]  tag;
		logic [15:0] arrival;
		logic [15:0] cpu;
	} arr_entry_t;

	typedef struct packed {
		logic [7:0]  tag;
		logic [15:0] remaining;
		logic        started;
	} rdy_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARRIVE,
		ST_RUN,
		ST_FINISH,
		ST_PREEMPT,
		ST_DISPATCH
	} state_t;

	localparam logic [15:0] TICK_MAX = 16'hFFFF;

endpackage

// ===== sv/round_robin_job_dispatcher_unit.sv =====
// round_robin_job_dispatcher_unit: round-robin scheduler, quantum of one tick
// arrival and ready queues in synchronous memories, sequenced by a small fsm
// depends on rrjd_pkg
//
//   channel   ports                    handshake
//   command   start, busy, cmd         taken at the edge with start high and busy low
//   result    strobe, result           one cycle per transaction, no back-pressure
//
// a submit is handled without leaving idle; its result shows in the next cycle.
// a tick steps through the arrival state once per arrival and once more for
// the empty arrival check, then dispatch alone, the run step alone, or the run
// step with finish or preempt and dispatch;
// the arrival queue read port (one head entry a cycle) sets the arrival rate.
// results follow the sequencer through a single register, at most one per cycle.
// reset clears pointers, counts, running job and timer; queue contents are not
// cleared. the next command can be taken while the final result is shown.
module round_robin_job_dispatcher_unit #(
	parameter int JOB_SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rrjd_pkg::cmd_t    cmd,
	output logic             strobe,
	output rrjd_pkg::result_t result
);
	import rrjd_pkg::*;

	localparam int IW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
	localparam int CW = $clog2(JOB_SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(JOB_SLOTS - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(JOB_SLOTS);

	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
		next_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	state_t state_q, state_d;

	arr_entry_t arr_mem [JOB_SLOTS];
	rdy_entry_t rdy_mem [JOB_SLOTS];
	arr_entry_t arr_rdata_q, arr_wdata;
	rdy_entry_t rdy_rdata_q, rdy_wdata;
	logic arr_we, rdy_we;

	logic [IW-1:0] arr_head_q, arr_head_d, arr_tail_q, arr_tail_d;
	logic [IW-1:0] rdy_head_q, rdy_head_d, rdy_tail_q, rdy_tail_d;
	logic [CW-1:0] arr_count_q, arr_count_d, rdy_count_q, rdy_count_d;
	logic [CW-1:0] jobs_q, jobs_d;
	rdy_entry_t run_q, run_d;
	logic running_q, running_d;
	logic [15:0] tick_q, tick_d, tick_inc;
	result_t result_q, result_d;
	logic strobe_q, strobe_d;
	logic done;
	logic [15:0] rem_next;

	// queue memories, read at the next head so data is ready in the next cycle;
	// ready pushes never hit the head entry in the cycle before dispatch reads it
	always_ff @(posedge clk) begin
		if (arr_we)
			arr_mem[arr_tail_q] <= arr_wdata;
		arr_rdata_q <= arr_mem[arr_head_d];
	end

	always_ff @(posedge clk) begin
		if (rdy_we)
			rdy_mem[rdy_tail_q] <= rdy_wdata;
		rdy_rdata_q <= rdy_mem[rdy_head_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			arr_head_q  <= '0;
			arr_tail_q  <= '0;
			arr_count_q <= '0;
			rdy_head_q  <= '0;
			rdy_tail_q  <= '0;
			rdy_count_q <= '0;
			jobs_q      <= '0;
			run_q       <= '0;
			running_q   <= 1'b0;
			tick_q      <= '0;
			strobe_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			arr_head_q  <= arr_head_d;
			arr_tail_q  <= arr_tail_d;
			arr_count_q <= arr_count_d;
			rdy_head_q  <= rdy_head_d;
			rdy_tail_q  <= rdy_tail_d;
			rdy_count_q <= rdy_count_d;
			jobs_q      <= jobs_d;
			run_q       <= run_d;
			running_q   <= running_d;
			tick_q      <= tick_d;
			strobe_q    <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 16'd1;
	assign done     = (run_q.remaining <= 16'd1);
	assign rem_next = done ? 16'd0 : run_q.remaining - 16'd1;

	always_comb begin
		state_d     = state_q;
		arr_head_d  = arr_head_q;
		arr_tail_d  = arr_tail_q;
		arr_count_d = arr_count_q;
		rdy_head_d  = rdy_head_q;
		rdy_tail_d  = rdy_tail_q;
		rdy_count_d = rdy_count_q;
		jobs_d      = jobs_q;
		run_d       = run_q;
		running_d   = running_q;
		tick_d      = tick_q;
		arr_we      = 1'b0;
		arr_wdata   = '{tag: cmd.job_tag, arrival: cmd.arrival_time, cpu: cmd.cpu_time};
		rdy_we      = 1'b0;
		rdy_wdata   = '{tag: arr_rdata_q.tag, remaining: arr_rdata_q.cpu, started: 1'b0};
		strobe_d    = 1'b0;
		result_d    = '{event_res: EV_IDLE, event_tag: '0, remaining_time: '0,
		                tick_time: tick_q, last: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cmd.opcode == OP_SUBMIT) begin
						strobe_d                = 1'b1;
						result_d.event_tag      = cmd.job_tag;
						result_d.remaining_time = cmd.cpu_time;
						result_d.last           = 1'b1;
						if (jobs_q >= FULL_CNT || arr_count_q >= FULL_CNT) begin
							result_d.event_res = EV_REJECTED;
						end else begin
							result_d.event_res = EV_ACCEPTED;
							arr_we      = 1'b1;
							arr_tail_d  = next_idx(arr_tail_q);
							arr_count_d = arr_count_q + 1'b1;
							jobs_d      = jobs_q + 1'b1;
						end
					end else begin
						state_d = ST_ARRIVE;
					end
				end
			end
			ST_ARRIVE: begin
				if (arr_count_q != '0 && arr_rdata_q.arrival <= tick_q) begin
					strobe_d                = 1'b1;
					result_d.event_res      = EV_ARRIVED;
					result_d.event_tag      = arr_rdata_q.tag;
					result_d.remaining_time = arr_rdata_q.cpu;
					arr_head_d  = next_idx(arr_head_q);
					arr_count_d = arr_count_q - 1'b1;
					rdy_we      = 1'b1;
					rdy_tail_d  = next_idx(rdy_tail_q);
					rdy_count_d = rdy_count_q + 1'b1;
				end else begin
					state_d = running_q ? ST_RUN : ST_DISPATCH;
				end
			end
			ST_RUN: begin
				strobe_d                = 1'b1;
				result_d.event_res      = EV_RAN;
				result_d.event_tag      = run_q.tag;
				result_d.remaining_time = rem_next;
				run_d.remaining         = rem_next;
				if (done) begin
					running_d = 1'b0;
					if (jobs_q != '0)
						jobs_d = jobs_q - 1'b1;
					state_d = ST_FINISH;
				end else if (rdy_count_q != '0) begin
					state_d = ST_PREEMPT;
				end else begin
					result_d.last = 1'b1;
					tick_d        = tick_inc;
					state_d       = ST_IDLE;
				end
			end
			ST_FINISH: begin
				strobe_d           = 1'b1;
				result_d.event_res = EV_FINISHED;
				result_d.event_tag = run_q.tag;
				state_d            = ST_DISPATCH;
			end
			ST_PREEMPT: begin
				strobe_d                = 1'b1;
				result_d.event_res      = EV_PREEMPTED;
				result_d.event_tag      = run_q.tag;
				result_d.remaining_time = run_q.remaining;
				rdy_we      = 1'b1;
				rdy_wdata   = run_q;
				rdy_tail_d  = next_idx(rdy_tail_q);
				rdy_count_d = rdy_count_q + 1'b1;
				running_d   = 1'b0;
				state_d     = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				strobe_d      = 1'b1;
				result_d.last = 1'b1;
				tick_d        = tick_inc;
				state_d       = ST_IDLE;
				if (rdy_count_q != '0) begin
					result_d.event_res      = rdy_rdata_q.started ? EV_RESUMED : EV_STARTED;
					result_d.event_tag      = rdy_rdata_q.tag;
					result_d.remaining_time = rdy_rdata_q.remaining;
					run_d         = rdy_rdata_q;
					run_d.started = 1'b1;
					running_d     = 1'b1;
					rdy_head_d    = next_idx(rdy_head_q);
					rdy_count_d   = rdy_count_q - 1'b1;
				end
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	logic [CW+1:0] occupancy;
	assign occupancy = {2'b00, arr_count_q} + {2'b00, rdy_count_q} + (CW+2)'(running_q);

	a_jobs_cover_held: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= {2'b00, jobs_q} && jobs_q <= FULL_CNT)
		else $error("held job count does not cover queued and running jobs");

	a_submit_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.opcode == OP_SUBMIT |=> strobe && result.last)
		else $error("submit did not give a single final result");

	a_last_frees_port: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.last == !busy))
		else $error("final result flag and busy disagree");

endmodule
